@@ rtl/core/pspsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspsc_pkg
// Shared types and constants of the per-source port scan classifier.
// ----------------------------------------------------------------------------
package pspsc_pkg;

    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;

    localparam logic [15:0] CFG_COUNT_THR_RST = 16'd5;
    localparam logic [15:0] CFG_RESET_LIM_RST = 16'd100;
    localparam logic [15:0] CFG_SEQ_LIM_RST   = 16'd5;
    localparam logic [15:0] CFG_HOR_LIM_RST   = 16'd5;

    localparam logic [1:0] REG_COUNT_THR = 2'd0;
    localparam logic [1:0] REG_RESET_LIM = 2'd1;
    localparam logic [1:0] REG_SEQ_LIM   = 2'd2;
    localparam logic [1:0] REG_HOR_LIM   = 2'd3;

    localparam logic [3:0] KIND_OTHER = 4'd0;
    localparam logic [3:0] KIND_SYN   = 4'd1;
    localparam logic [3:0] KIND_FIN   = 4'd4;
    localparam logic [3:0] KIND_XMAS  = 4'd6;
    localparam logic [3:0] KIND_NULL  = 4'd7;
    localparam logic [3:0] KIND_RST   = 4'd8;

    localparam logic [2:0] V_NONE  = 3'd0;
    localparam logic [2:0] V_SYN   = 3'd1;
    localparam logic [2:0] V_FIN   = 3'd2;
    localparam logic [2:0] V_XMAS  = 3'd3;
    localparam logic [2:0] V_NULL  = 3'd4;
    localparam logic [2:0] V_CONN  = 3'd5;
    localparam logic [2:0] V_SEQ   = 3'd6;
    localparam logic [2:0] V_HORIZ = 3'd7;

    // One classified packet handed from the front to the back.
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] dst_port;
        logic [3:0]  kind;
    } t_pkt;

    // Per-source record held in the table memory.
    typedef struct packed {
        logic [31:0] source;
        logic [15:0] total;
        logic [15:0] syn;
        logic [15:0] fin;
        logic [15:0] xmas;
        logic [15:0] nul;
        logic [15:0] rst;
        logic [15:0] seq;
        logic [15:0] horiz;
        logic [31:0] prev_ip;
        logic [15:0] prev_port;
        logic [3:0]  first_kind;
        logic [2:0]  verdict;
        logic [31:0] dest;
    } t_rec;

    typedef struct packed {
        logic [15:0] count_thr;
        logic [15:0] reset_lim;
        logic [15:0] seq_lim;
        logic [15:0] hor_lim;
    } t_cfg;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

@@ rtl/core/per_source_port_scan_classifier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_port_scan_classifier_core
// Per-source port scan classifier with a bucketed record table.
// ----------------------------------------------------------------------------
// Each packet header yields one result. A two-entry queue accepts headers
// while the table engine works; the engine takes one packet at a time, in
// the steps bucket read, read data register, update and result hand-off,
// set by the single read-modify-write of one bucket row of the table memory.
// Valid bits are cleared at reset at once, so no clearing pass is needed.
module per_source_port_scan_classifier_core #(
    parameter int BUCKETS = pspsc_pkg::BUCKETS_DEF,
    parameter int WAYS    = pspsc_pkg::WAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_dst_port,
    input  logic [3:0]  i_packet_kind,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic        o_inserted,
    output logic        o_table_full,
    output logic [2:0]  o_verdict,
    output logic [31:0] o_verdict_dest,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    pspsc_pkg::t_cfg r_cfg;
    pspsc_pkg::t_pkt w_in, w_q;
    logic w_qv, w_qr;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_thr <= pspsc_pkg::CFG_COUNT_THR_RST;
            r_cfg.reset_lim <= pspsc_pkg::CFG_RESET_LIM_RST;
            r_cfg.seq_lim   <= pspsc_pkg::CFG_SEQ_LIM_RST;
            r_cfg.hor_lim   <= pspsc_pkg::CFG_HOR_LIM_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pspsc_pkg::REG_COUNT_THR: r_cfg.count_thr <= i_cfg_data;
                pspsc_pkg::REG_RESET_LIM: r_cfg.reset_lim <= i_cfg_data;
                pspsc_pkg::REG_SEQ_LIM:   r_cfg.seq_lim   <= i_cfg_data;
                pspsc_pkg::REG_HOR_LIM:   r_cfg.hor_lim   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in = '{src_ip: i_src_ip, dst_ip: i_dst_ip, dst_port: i_dst_port,
                    kind: i_packet_kind};

    pspsc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_pkt(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_pkt(w_q)
    );

    pspsc_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_qv), .o_ready(w_qr), .i_pkt(w_q),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_found(o_found), .o_inserted(o_inserted), .o_table_full(o_table_full),
        .o_verdict(o_verdict), .o_verdict_dest(o_verdict_dest)
    );

endmodule

@@ rtl/core/pspsc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspsc_front
// Accepts packet headers, folds kinds above rst to other, and queues them.
// ----------------------------------------------------------------------------
module pspsc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  pspsc_pkg::t_pkt  i_pkt,
    output logic             o_valid,
    input  logic             i_ready,
    output pspsc_pkg::t_pkt  o_pkt
);

    // Two-entry queue.
    pspsc_pkg::t_pkt r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    pspsc_pkg::t_pkt w_cls;
    logic w_push, w_pop;

    // Classification: kinds above rst behave as other.
    always_comb begin
        w_cls = i_pkt;
        if (i_pkt.kind > pspsc_pkg::KIND_RST) w_cls.kind = pspsc_pkg::KIND_OTHER;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_pkt   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_cls;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ rtl/core/pspsc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspsc_back
// Reads a bucket, matches the ways, updates a hit record or inserts a new one, and writes it back.
// ----------------------------------------------------------------------------
module pspsc_back #(
    parameter int BUCKETS = pspsc_pkg::BUCKETS_DEF,
    parameter int WAYS    = pspsc_pkg::WAYS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pspsc_pkg::t_cfg  i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  pspsc_pkg::t_pkt  i_pkt,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_found,
    output logic             o_inserted,
    output logic             o_table_full,
    output logic [2:0]       o_verdict,
    output logic [31:0]      o_verdict_dest
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_OUT} t_state;
    t_state r_state;

    // Bucket memory: one row of WAYS records, valid bits in flip-flops.
    pspsc_pkg::t_rec r_mem [BUCKETS][WAYS];
    logic [WAYS-1:0] r_vld [BUCKETS];
    pspsc_pkg::t_rec r_row [WAYS];
    logic [WAYS-1:0] r_rowv;
    pspsc_pkg::t_pkt r_pkt;
    logic [BW-1:0]   r_bkt;
    logic [BW-1:0]   w_bkt;

    // Bucket index is src_ip mod BUCKETS.
    always_comb begin
        if (BUCKETS > 1) w_bkt = BW'(i_pkt.src_ip % 32'(BUCKETS));
        else w_bkt = '0;
    end

    // Way search and record update.
    logic            w_hit, w_free;
    logic [WW-1:0]   w_hway, w_fway, w_way;
    logic            w_ins_kind, w_wr;
    pspsc_pkg::t_rec w_old, w_new;
    logic            w_sip, w_spt, w_adj;
    logic [17:0]     w_t3;
    logic [18:0]     w_a5;
    logic [17:0]     w_a4;

    always_comb begin
        w_hit = 1'b0; w_free = 1'b0; w_hway = '0; w_fway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rowv[w] && r_row[w].source == r_pkt.src_ip) begin
                w_hit = 1'b1; w_hway = WW'(w);
            end
            if (!r_rowv[w]) begin
                w_free = 1'b1; w_fway = WW'(w);
            end
        end
        w_ins_kind = (r_pkt.kind == pspsc_pkg::KIND_SYN) || (r_pkt.kind == pspsc_pkg::KIND_FIN)
                  || (r_pkt.kind == pspsc_pkg::KIND_XMAS) || (r_pkt.kind == pspsc_pkg::KIND_NULL)
                  || (r_pkt.kind == pspsc_pkg::KIND_RST);
        w_way = w_hit ? w_hway : w_fway;
        w_old = r_row[w_hway];
        w_new = w_old;
        w_sip = (r_pkt.dst_ip == w_old.prev_ip);
        w_spt = (r_pkt.dst_port == w_old.prev_port);
        w_adj = ({1'b0, r_pkt.dst_port} == {1'b0, w_old.prev_port} + 17'd1)
             || ({1'b0, r_pkt.dst_port} + 17'd1 == {1'b0, w_old.prev_port});
        w_new.total = pspsc_pkg::sat_inc(w_old.total);
        w_t3 = {2'b0, w_new.total} + {1'b0, w_new.total, 1'b0};
        w_a5 = '0; w_a4 = '0;
        w_wr = 1'b0;
        if (w_hit) begin
            w_wr = 1'b1;
            if (!(w_sip && w_spt && r_pkt.kind == w_old.first_kind)) begin
                case (r_pkt.kind)
                    pspsc_pkg::KIND_SYN: begin
                        w_new.syn = pspsc_pkg::sat_inc(w_old.syn);
                        w_a5 = {3'b0, w_new.syn} + {1'b0, w_new.syn, 2'b0};
                        if (w_new.syn >= i_cfg.count_thr && w_a5 >= {1'b0, w_t3}
                            && w_old.verdict != pspsc_pkg::V_CONN) begin
                            w_new.verdict = pspsc_pkg::V_SYN;
                            w_new.dest = r_pkt.dst_ip;
                        end
                    end
                    pspsc_pkg::KIND_FIN: begin
                        w_new.fin = pspsc_pkg::sat_inc(w_old.fin);
                        w_a5 = {3'b0, w_new.fin} + {1'b0, w_new.fin, 2'b0};
                        if (w_new.fin >= i_cfg.count_thr && w_a5 > {1'b0, w_t3}) begin
                            w_new.verdict = pspsc_pkg::V_FIN;
                            w_new.dest = r_pkt.dst_ip;
                        end
                    end
                    pspsc_pkg::KIND_XMAS: begin
                        w_new.xmas = pspsc_pkg::sat_inc(w_old.xmas);
                        w_a4 = {w_new.xmas, 2'b0};
                        if (w_new.xmas >= i_cfg.count_thr && w_a4 > w_t3) begin
                            w_new.verdict = pspsc_pkg::V_XMAS;
                            w_new.dest = r_pkt.dst_ip;
                        end
                    end
                    pspsc_pkg::KIND_NULL: begin
                        w_new.nul = pspsc_pkg::sat_inc(w_old.nul);
                        w_new.verdict = pspsc_pkg::V_NULL;
                        w_new.dest = r_pkt.dst_ip;
                    end
                    pspsc_pkg::KIND_RST: begin
                        w_new.rst = pspsc_pkg::sat_inc(w_old.rst);
                        if (w_new.rst > i_cfg.reset_lim) begin
                            w_new.verdict = pspsc_pkg::V_CONN;
                            w_new.dest = r_pkt.dst_ip;
                        end
                    end
                    default: ;
                endcase
                // Sequential-port probe.
                if (w_sip && !w_spt && w_adj) begin
                    w_new.seq = pspsc_pkg::sat_inc(w_old.seq);
                    if (w_new.seq >= i_cfg.seq_lim) w_new.verdict = pspsc_pkg::V_SEQ;
                end
                // Horizontal probe.
                if (!w_sip && w_spt) begin
                    w_new.horiz = pspsc_pkg::sat_inc(w_old.horiz);
                    if (w_new.horiz >= i_cfg.hor_lim) w_new.verdict = pspsc_pkg::V_HORIZ;
                end
                w_new.prev_ip   = r_pkt.dst_ip;
                w_new.prev_port = r_pkt.dst_port;
            end
        end else if (w_ins_kind && w_free) begin
            w_wr = 1'b1;
            w_new = '0;
            w_new.source     = r_pkt.src_ip;
            w_new.total      = 16'd1;
            w_new.seq        = 16'd1;
            w_new.prev_ip    = r_pkt.dst_ip;
            w_new.prev_port  = r_pkt.dst_port;
            w_new.first_kind = r_pkt.kind;
            w_new.syn  = {15'd0, r_pkt.kind == pspsc_pkg::KIND_SYN};
            w_new.fin  = {15'd0, r_pkt.kind == pspsc_pkg::KIND_FIN};
            w_new.xmas = {15'd0, r_pkt.kind == pspsc_pkg::KIND_XMAS};
            w_new.nul  = {15'd0, r_pkt.kind == pspsc_pkg::KIND_NULL};
            w_new.rst  = {15'd0, r_pkt.kind == pspsc_pkg::KIND_RST};
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // Memory ports: row read on accept, record write after evaluation.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_row <= r_mem[w_bkt];
            r_pkt <= i_pkt;
            r_bkt <= w_bkt;
        end
        if (r_state == S_EVAL && w_wr) r_mem[r_bkt][w_way] <= w_new;
    end

    // Sequencer, valid bits and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int b = 0; b < BUCKETS; b++) r_vld[b] <= '0;
            r_rowv  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_rowv  <= r_vld[w_bkt];
                    r_state <= S_READ;
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    if (w_wr) r_vld[r_bkt][w_way] <= 1'b1;
                    o_found        <= w_hit;
                    o_inserted     <= !w_hit && w_ins_kind && w_free;
                    o_table_full   <= !w_hit && w_ins_kind && !w_free;
                    o_verdict      <= w_hit ? w_new.verdict : pspsc_pkg::V_NONE;
                    o_verdict_dest <= w_hit ? w_new.dest : 32'd0;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
